### sv/trp_pkg.sv
`default_nettype none
package trp_pkg;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_SHUTDOWN = 3'd1,
    ACT_CHECKOUT = 3'd2,
    ACT_RETURN   = 3'd3,
    ACT_EVICT    = 3'd4,
    ACT_PREWARM  = 3'd5,
    ACT_RSVD6    = 3'd6,
    ACT_RSVD7    = 3'd7
  } action_t;

  localparam logic [2:0] CFG_MAX_POOL_SIZE  = 3'd0;
  localparam logic [2:0] CFG_MIN_POOL_SIZE  = 3'd1;
  localparam logic [2:0] CFG_TTL_SECONDS    = 3'd2;
  localparam logic [2:0] CFG_ENABLE_PREWARM = 3'd3;

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_SCAN,
    ST_HIT_WRITE,
    ST_COUNT_START,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  kind;
    logic        busy;
    logic [31:0] last_used;
    logic [31:0] uses;
  } entry_t;

  typedef struct packed {
    logic load;
    logic init_clear;
    logic shut;
    logic pass_start;
    logic pass_step;
    logic scan_eval;
    logic count_eval;
    logic fill_append;
    logic fill_next;
    logic hit_write;
    logic miss_end;
    logic evict_end;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    inited;
    logic    prewarm_en;
    logic    kind_ok;
    logic    match;
    logic    pass_end;
    logic    fill_go;
    logic    fill_last;
    logic    out_free;
  } stat_t;

endpackage
`default_nettype wire

### sv/trp_if.sv
`default_nettype none
interface trp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  res_kind;
  logic [31:0] release_id;
  logic [4:0]  prewarm_count;
  logic [31:0] now_ms;
  modport source (output valid, action, res_kind, release_id, prewarm_count, now_ms,
                  input ready);
  modport sink (input valid, action, res_kind, release_id, prewarm_count, now_ms,
                output ready);
endinterface

interface trp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] granted_id;
  logic [2:0]  granted_kind;
  logic [31:0] use_total;
  logic        was_hit;
  logic [4:0]  changed_count;
  logic [4:0]  free_of_kind;
  logic [4:0]  busy_of_kind;
  logic [4:0]  pool_size;
  logic [4:0]  peak_size;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  modport source (output valid, ok, granted_id, granted_kind, use_total, was_hit,
                  changed_count, free_of_kind, busy_of_kind, pool_size, peak_size,
                  hit_total, miss_total, input ready);
  modport sink (input valid, ok, granted_id, granted_kind, use_total, was_hit,
                changed_count, free_of_kind, busy_of_kind, pool_size, peak_size,
                hit_total, miss_total, output ready);
endinterface

interface trp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/trp_ram.sv
`default_nettype none
module trp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### sv/trp_ctrl.sv
`default_nettype none
module trp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire trp_pkg::stat_t st,
  output trp_pkg::cmd_t      cmd
);
  trp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      trp_pkg::ST_IDLE: begin
        if (in_valid) state_next = trp_pkg::ST_DISPATCH;
      end
      trp_pkg::ST_DISPATCH: begin
        unique case (st.action)
          trp_pkg::ACT_INIT: begin
            if (!st.inited && st.prewarm_en) state_next = trp_pkg::ST_FILL;
            else state_next = trp_pkg::ST_COUNT_START;
          end
          trp_pkg::ACT_CHECKOUT: begin
            state_next = st.kind_ok ? trp_pkg::ST_SCAN : trp_pkg::ST_COUNT_START;
          end
          trp_pkg::ACT_RETURN, trp_pkg::ACT_EVICT: state_next = trp_pkg::ST_SCAN;
          trp_pkg::ACT_PREWARM: state_next = trp_pkg::ST_FILL;
          default: state_next = trp_pkg::ST_COUNT_START;
        endcase
      end
      trp_pkg::ST_FILL: begin
        if (!st.fill_go && st.fill_last) state_next = trp_pkg::ST_COUNT_START;
      end
      trp_pkg::ST_SCAN: begin
        if (st.match) state_next = trp_pkg::ST_HIT_WRITE;
        else if (st.pass_end) state_next = trp_pkg::ST_COUNT_START;
      end
      trp_pkg::ST_HIT_WRITE: state_next = trp_pkg::ST_COUNT_START;
      trp_pkg::ST_COUNT_START: state_next = trp_pkg::ST_COUNT;
      trp_pkg::ST_COUNT: begin
        if (st.pass_end) state_next = trp_pkg::ST_DONE;
      end
      trp_pkg::ST_DONE: begin
        if (st.out_free) state_next = trp_pkg::ST_IDLE;
      end
      default: state_next = trp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == trp_pkg::ST_IDLE);
    unique case (state)
      trp_pkg::ST_IDLE: cmd.load = in_valid;
      trp_pkg::ST_DISPATCH: begin
        unique case (st.action)
          trp_pkg::ACT_INIT: cmd.init_clear = !st.inited;
          trp_pkg::ACT_SHUTDOWN: cmd.shut = 1'b1;
          trp_pkg::ACT_CHECKOUT: cmd.pass_start = st.kind_ok;
          trp_pkg::ACT_RETURN, trp_pkg::ACT_EVICT: cmd.pass_start = 1'b1;
          default: ;
        endcase
      end
      trp_pkg::ST_FILL: begin
        cmd.fill_append = st.fill_go;
        cmd.fill_next = !st.fill_go && !st.fill_last;
      end
      trp_pkg::ST_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (!st.match) begin
          if (st.pass_end) begin
            cmd.miss_end = (st.action == trp_pkg::ACT_CHECKOUT);
            cmd.evict_end = (st.action == trp_pkg::ACT_EVICT);
          end else begin
            cmd.pass_step = 1'b1;
          end
        end
      end
      trp_pkg::ST_HIT_WRITE: cmd.hit_write = 1'b1;
      trp_pkg::ST_COUNT_START: cmd.pass_start = 1'b1;
      trp_pkg::ST_COUNT: begin
        cmd.count_eval = 1'b1;
        cmd.pass_step = !st.pass_end;
      end
      trp_pkg::ST_DONE: cmd.result_load = st.out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### sv/trp_datapath.sv
`default_nettype none
module trp_datapath #(
  parameter int POOL_DEPTH = 16,
  parameter int NUM_KINDS  = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire trp_pkg::cmd_t cmd,
  output trp_pkg::stat_t     st,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic [2:0]    in_action,
  input  wire logic [2:0]    in_res_kind,
  input  wire logic [31:0]   in_release_id,
  input  wire logic [4:0]    in_prewarm_count,
  input  wire logic [31:0]   in_now_ms,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_ok,
  output logic [31:0]        out_granted_id,
  output logic [2:0]         out_granted_kind,
  output logic [31:0]        out_use_total,
  output logic               out_was_hit,
  output logic [4:0]         out_changed_count,
  output logic [4:0]         out_free_of_kind,
  output logic [4:0]         out_busy_of_kind,
  output logic [4:0]         out_pool_size,
  output logic [4:0]         out_peak_size,
  output logic [31:0]        out_hit_total,
  output logic [31:0]        out_miss_total
);
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int EW = $bits(trp_pkg::entry_t);

  // Configuration registers.
  logic [4:0]  max_pool_size, min_pool_size;
  logic [15:0] ttl_seconds;
  logic        enable_prewarm;

  // Persistent pool state.
  logic [CW-1:0] occ;
  logic [31:0]   next_id;
  logic          inited;
  logic [LW-1:0] peak;
  logic [31:0]   hits, misses;

  // Current transaction.
  trp_pkg::action_t action;
  logic [2:0]  kind;
  logic [31:0] rid, now, limit_ms;
  logic [2:0]  fk;
  logic [4:0]  tgt, made;

  // Scan bookkeeping and per-transaction results.
  logic [CW-1:0] ptr, keep;
  logic          rv;
  logic [AW-1:0] ri;
  logic [LW-1:0] changed, nfree, nbusy;
  logic          r_ok, r_hit;
  logic [31:0]   r_gid, r_guses;
  logic [2:0]    r_gkind;

  trp_pkg::entry_t rd, wentry, app_entry;
  logic [EW-1:0]   rdata;
  logic            we;
  logic [AW-1:0]   waddr;

  logic [LW-1:0] limit, occ_w, max_w;
  logic          room, match, evict_hit, kept, do_append;
  logic [31:0]   idle, uses_inc, id_inc;

  assign rd = trp_pkg::entry_t'(rdata);
  assign occ_w = LW'(occ);
  assign max_w = LW'(max_pool_size);
  assign limit = (max_w > LW'(POOL_DEPTH)) ? LW'(POOL_DEPTH) : max_w;
  assign room = occ_w < limit;
  assign idle = now - rd.last_used;
  assign uses_inc = (rd.uses == 32'hFFFF_FFFF) ? rd.uses : rd.uses + 32'd1;
  assign id_inc = (next_id + 32'd1 == 32'd0) ? 32'd1 : next_id + 32'd1;

  always_comb begin
    match = 1'b0;
    if (rv) begin
      if (action == trp_pkg::ACT_CHECKOUT) match = (rd.kind == kind) && !rd.busy;
      else if (action == trp_pkg::ACT_RETURN) match = (rd.id == rid) && rd.busy;
    end
  end

  assign evict_hit = !rd.busy && (idle > limit_ms);
  assign kept = cmd.scan_eval && rv && (action == trp_pkg::ACT_EVICT) && !evict_hit;
  assign do_append = cmd.fill_append || (cmd.miss_end && room);

  always_comb begin
    app_entry.id = next_id;
    app_entry.kind = cmd.fill_append ? fk : kind;
    app_entry.busy = !cmd.fill_append;
    app_entry.last_used = now;
    app_entry.uses = cmd.fill_append ? 32'd0 : 32'd1;
  end

  always_comb begin
    we = 1'b0;
    waddr = occ[AW-1:0];
    wentry = app_entry;
    if (do_append) begin
      we = 1'b1;
    end else if (cmd.hit_write) begin
      we = 1'b1;
      waddr = ri;
      wentry = rd;
      wentry.last_used = now;
      wentry.busy = (action == trp_pkg::ACT_CHECKOUT);
      if (action == trp_pkg::ACT_CHECKOUT) wentry.uses = uses_inc;
    end else if (kept) begin
      we = 1'b1;
      waddr = keep[AW-1:0];
      wentry = rd;
    end
  end

  trp_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (EW'(wentry)),
    .re    (cmd.pass_step),
    .raddr (ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pool_size <= 5'd16;
      min_pool_size <= 5'd2;
      ttl_seconds <= 16'd60;
      enable_prewarm <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        trp_pkg::CFG_MAX_POOL_SIZE:  max_pool_size <= cfg_data[4:0];
        trp_pkg::CFG_MIN_POOL_SIZE:  min_pool_size <= cfg_data[4:0];
        trp_pkg::CFG_TTL_SECONDS:    ttl_seconds <= cfg_data;
        trp_pkg::CFG_ENABLE_PREWARM: enable_prewarm <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      next_id <= 32'd1;
      inited <= 1'b0;
      peak <= '0;
      hits <= '0;
      misses <= '0;
      rv <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init_clear) begin
        occ <= '0;
        peak <= '0;
        hits <= '0;
        misses <= '0;
        next_id <= 32'd1;
        inited <= 1'b1;
      end
      if (cmd.shut) begin
        occ <= '0;
        inited <= 1'b0;
      end
      if (do_append) begin
        occ <= occ + CW'(1);
        next_id <= id_inc;
        if (occ_w + LW'(1) > peak) peak <= occ_w + LW'(1);
      end
      if (cmd.miss_end) misses <= misses + 32'd1;
      if (cmd.hit_write && action == trp_pkg::ACT_CHECKOUT) hits <= hits + 32'd1;
      if (cmd.evict_end) occ <= keep;
      if (cmd.pass_start) rv <= 1'b0;
      else if (cmd.pass_step) rv <= (ptr < occ);
      if (cmd.result_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= trp_pkg::action_t'(in_action);
      kind <= in_res_kind;
      rid <= in_release_id;
      now <= in_now_ms;
      limit_ms <= 32'(ttl_seconds) * trp_pkg::MS_PER_SECOND;
      fk <= (in_action == trp_pkg::ACT_INIT) ? 3'd0 : in_res_kind;
      tgt <= (in_action == trp_pkg::ACT_INIT) ? min_pool_size : in_prewarm_count;
      made <= '0;
      changed <= '0;
      nfree <= '0;
      nbusy <= '0;
      r_ok <= 1'b0;
      r_hit <= 1'b0;
      r_gid <= '0;
      r_guses <= '0;
      r_gkind <= '0;
    end
    if (cmd.init_clear) r_ok <= 1'b1;
    if (cmd.fill_append) begin
      made <= made + 5'd1;
      changed <= changed + LW'(1);
    end
    if (cmd.fill_next) begin
      fk <= fk + 3'd1;
      made <= '0;
    end
    if (cmd.pass_start) begin
      ptr <= '0;
      keep <= '0;
    end else if (cmd.pass_step) begin
      ri <= ptr[AW-1:0];
      if (ptr < occ) ptr <= ptr + CW'(1);
    end
    if (cmd.scan_eval && rv && action == trp_pkg::ACT_EVICT) begin
      if (evict_hit) changed <= changed + LW'(1);
      else keep <= keep + CW'(1);
    end
    if (cmd.count_eval && rv && rd.kind == kind) begin
      if (rd.busy) nbusy <= nbusy + LW'(1);
      else nfree <= nfree + LW'(1);
    end
    if (cmd.hit_write) begin
      r_ok <= 1'b1;
      if (action == trp_pkg::ACT_CHECKOUT) begin
        r_hit <= 1'b1;
        r_gid <= rd.id;
        r_gkind <= kind;
        r_guses <= uses_inc;
      end
    end
    if (cmd.miss_end && room) begin
      r_ok <= 1'b1;
      r_gid <= next_id;
      r_gkind <= kind;
      r_guses <= 32'd1;
    end
    if (cmd.result_load) begin
      out_ok <= r_ok;
      out_granted_id <= r_gid;
      out_granted_kind <= r_gkind;
      out_use_total <= r_guses;
      out_was_hit <= r_hit;
      out_changed_count <= changed[4:0];
      out_free_of_kind <= nfree[4:0];
      out_busy_of_kind <= nbusy[4:0];
      out_pool_size <= occ_w[4:0];
      out_peak_size <= peak[4:0];
      out_hit_total <= hits;
      out_miss_total <= misses;
    end
  end

  always_comb begin
    st.action = action;
    st.inited = inited;
    st.prewarm_en = enable_prewarm;
    st.kind_ok = {1'b0, kind} < 4'(NUM_KINDS);
    st.match = match;
    st.pass_end = !rv && (ptr >= occ);
    st.fill_go = ({1'b0, fk} < 4'(NUM_KINDS)) && (made < tgt) && room;
    st.fill_last = (action != trp_pkg::ACT_INIT) || (fk == 3'(NUM_KINDS - 1));
    st.out_free = !out_valid || out_ready;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(POOL_DEPTH)) else $error("table occupancy beyond depth");
  a_peak_covers_occ: assert property (@(posedge clk) disable iff (rst)
    peak >= occ_w) else $error("peak below current occupancy");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != 32'd0) else $error("next id reached zero");
  a_pass_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.pass_start |=> !rv) else $error("stale read pending after pass start");
  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_eval |-> keep <= ptr) else $error("compaction pointer ran ahead of scan");
endmodule
`default_nettype wire

### sv/typed_resource_pool_ttl_unit.sv
// Typed resource pool with idle-time eviction. Each transaction on in_ch yields
// exactly one result on out_ch; transactions are processed one at a time. The
// table lives in a single-port-write RAM with registered read, so every action
// walks it one entry per cycle: the action pass (checkout, return, evict) plus a
// second pass that counts the free and busy entries of res_kind, and fills
// append one entry per cycle, stepping through the kinds one by one during an
// init. A new transaction is accepted while the previous result still waits on
// out_ch. Configuration writes are always accepted and should be issued only
// while the block is idle.
`default_nettype none
module typed_resource_pool_ttl_unit #(
  parameter int POOL_DEPTH = 16,
  parameter int NUM_KINDS  = 6
) (
  input wire logic   clk,
  input wire logic   rst,
  trp_in_if.sink     in_ch,
  trp_out_if.source  out_ch,
  trp_cfg_if.sink    cfg
);
  trp_pkg::cmd_t  cmd;
  trp_pkg::stat_t st;

  assign cfg.ready = 1'b1;

  trp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  trp_datapath #(.POOL_DEPTH(POOL_DEPTH), .NUM_KINDS(NUM_KINDS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .in_action         (in_ch.action),
    .in_res_kind       (in_ch.res_kind),
    .in_release_id     (in_ch.release_id),
    .in_prewarm_count  (in_ch.prewarm_count),
    .in_now_ms         (in_ch.now_ms),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_ok            (out_ch.ok),
    .out_granted_id    (out_ch.granted_id),
    .out_granted_kind  (out_ch.granted_kind),
    .out_use_total     (out_ch.use_total),
    .out_was_hit       (out_ch.was_hit),
    .out_changed_count (out_ch.changed_count),
    .out_free_of_kind  (out_ch.free_of_kind),
    .out_busy_of_kind  (out_ch.busy_of_kind),
    .out_pool_size     (out_ch.pool_size),
    .out_peak_size     (out_ch.peak_size),
    .out_hit_total     (out_ch.hit_total),
    .out_miss_total    (out_ch.miss_total)
  );
endmodule
`default_nettype wire

### tb/tb_pool_if.sv
`default_nettype none
// The block's channel interfaces are defined with the RTL; this file holds
// the testbench-side item types shared by the driver and the monitor.
package tb_pool_types;

  typedef struct {
    trp_pkg::action_t action;
    logic [2:0]  res_kind;
    logic [31:0] release_id;
    logic [4:0]  prewarm_count;
    logic [31:0] now_ms;
  } request_t;

  typedef struct {
    logic        ok;
    logic [31:0] granted_id;
    logic [2:0]  granted_kind;
    logic [31:0] use_total;
    logic        was_hit;
    logic [4:0]  changed_count;
    logic [4:0]  free_of_kind;
    logic [4:0]  busy_of_kind;
    logic [4:0]  pool_size;
    logic [4:0]  peak_size;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } outcome_t;
endpackage
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int KINDS = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  trp_in_if  in_ch();
  trp_out_if out_ch();
  trp_cfg_if cfg();

  typed_resource_pool_ttl_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // Shadow copy of the pool.
  logic [31:0] p_id[DEPTH];
  logic [2:0]  p_kind[DEPTH];
  logic        p_busy[DEPTH];
  logic [31:0] p_last[DEPTH];
  logic [31:0] p_uses[DEPTH];
  int unsigned p_count = 0;
  logic [31:0] p_next_id = 32'd1;
  logic        p_inited = 1'b0;
  int unsigned p_peak = 0;
  logic [31:0] p_hits = 0, p_misses = 0;
  logic [4:0]  r_max = 5'd16, r_min = 5'd2;
  logic [15:0] r_ttl = 16'd60;
  logic        r_prewarm = 1'b1;

  tb_pool_types::request_t pending_requests[$];
  tb_pool_types::outcome_t expected_outcomes[$];
  int errors = 0;
  int send_idle_pct = 14, recv_idle_pct = 66;
  logic hold_sender = 1'b0;

  function automatic int unsigned pool_limit();
    return (r_max > DEPTH) ? DEPTH : r_max;
  endfunction

  function automatic logic [31:0] issue_id();
    logic [31:0] id;
    id = p_next_id;
    p_next_id = p_next_id + 1;
    if (p_next_id == 0) p_next_id = 1;
    return id;
  endfunction

  function automatic void append_slot(logic [2:0] k, logic b, logic [31:0] now);
    p_id[p_count] = issue_id();
    p_kind[p_count] = k;
    p_busy[p_count] = b;
    p_last[p_count] = now;
    p_uses[p_count] = b ? 32'd1 : 32'd0;
    p_count++;
    if (p_count > p_peak) p_peak = p_count;
  endfunction

  function automatic int unsigned fill_slots(logic [2:0] k, int unsigned want,
                                             logic [31:0] now);
    int unsigned made;
    made = 0;
    if (k >= KINDS) return 0;
    while (made < want && p_count < pool_limit()) begin
      append_slot(k, 1'b0, now);
      made++;
    end
    return made;
  endfunction

  function automatic tb_pool_types::outcome_t pool_outcome(tb_pool_types::request_t r);
    tb_pool_types::outcome_t o;
    int unsigned keep;
    logic [31:0] limit_ms;
    o = '{default: '0};
    case (r.action)
      trp_pkg::ACT_INIT: begin
        if (!p_inited) begin
          p_count = 0; p_peak = 0; p_hits = 0; p_misses = 0; p_next_id = 1;
          if (r_prewarm)
            for (int k = 0; k < KINDS; k++)
              o.changed_count = 5'(o.changed_count + fill_slots(k[2:0], r_min, r.now_ms));
          p_inited = 1'b1;
          o.ok = 1'b1;
        end
      end
      trp_pkg::ACT_SHUTDOWN: begin
        p_count = 0;
        p_inited = 1'b0;
      end
      trp_pkg::ACT_CHECKOUT: begin
        if (r.res_kind < KINDS) begin
          for (int i = 0; i < p_count; i++) begin
            if (p_kind[i] == r.res_kind && !p_busy[i]) begin
              p_busy[i] = 1'b1;
              p_last[i] = r.now_ms;
              if (p_uses[i] != '1) p_uses[i]++;
              p_hits++;
              o.ok = 1; o.was_hit = 1;
              o.granted_id = p_id[i]; o.granted_kind = r.res_kind;
              o.use_total = p_uses[i];
              break;
            end
          end
          if (!o.was_hit) begin
            p_misses++;
            if (p_count < pool_limit()) begin
              append_slot(r.res_kind, 1'b1, r.now_ms);
              o.ok = 1; o.granted_id = p_id[p_count-1];
              o.granted_kind = r.res_kind; o.use_total = 1;
            end
          end
        end
      end
      trp_pkg::ACT_RETURN: begin
        for (int i = 0; i < p_count; i++) begin
          if (p_id[i] == r.release_id && p_busy[i]) begin
            p_busy[i] = 1'b0;
            p_last[i] = r.now_ms;
            o.ok = 1;
            break;
          end
        end
      end
      trp_pkg::ACT_EVICT: begin
        limit_ms = r_ttl * trp_pkg::MS_PER_SECOND;
        keep = 0;
        for (int i = 0; i < p_count; i++) begin
          if (!p_busy[i] && (r.now_ms - p_last[i]) > limit_ms) begin
            o.changed_count++;
          end else begin
            p_id[keep] = p_id[i]; p_kind[keep] = p_kind[i]; p_busy[keep] = p_busy[i];
            p_last[keep] = p_last[i]; p_uses[keep] = p_uses[i];
            keep++;
          end
        end
        p_count = keep;
      end
      trp_pkg::ACT_PREWARM:
        o.changed_count = 5'(fill_slots(r.res_kind, r.prewarm_count, r.now_ms));
      default: ;
    endcase
    for (int i = 0; i < p_count; i++)
      if (p_kind[i] == r.res_kind) begin
        if (p_busy[i]) o.busy_of_kind++;
        else o.free_of_kind++;
      end
    o.pool_size = p_count[4:0];
    o.peak_size = p_peak[4:0];
    o.hit_total = p_hits;
    o.miss_total = p_misses;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_requests.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        tb_pool_types::request_t r;
        r = pending_requests.pop_front();
        expected_outcomes = {expected_outcomes, pool_outcome(r)};
        in_ch.valid <= 1'b1;
        in_ch.action <= r.action;
        in_ch.res_kind <= r.res_kind;
        in_ch.release_id <= r.release_id;
        in_ch.prewarm_count <= r.prewarm_count;
        in_ch.now_ms <= r.now_ms;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected transaction", '0, '0);
        end else begin
          tb_pool_types::outcome_t e;
          e = expected_outcomes.pop_front();
          if (out_ch.ok !== e.ok) report_mismatch("ok", out_ch.ok, e.ok);
          if (out_ch.granted_id !== e.granted_id)
            report_mismatch("granted_id", out_ch.granted_id, e.granted_id);
          if (out_ch.granted_kind !== e.granted_kind)
            report_mismatch("granted_kind", out_ch.granted_kind, e.granted_kind);
          if (out_ch.use_total !== e.use_total)
            report_mismatch("use_total", out_ch.use_total, e.use_total);
          if (out_ch.was_hit !== e.was_hit)
            report_mismatch("was_hit", out_ch.was_hit, e.was_hit);
          if (out_ch.changed_count !== e.changed_count)
            report_mismatch("changed_count", out_ch.changed_count, e.changed_count);
          if (out_ch.free_of_kind !== e.free_of_kind)
            report_mismatch("free_of_kind", out_ch.free_of_kind, e.free_of_kind);
          if (out_ch.busy_of_kind !== e.busy_of_kind)
            report_mismatch("busy_of_kind", out_ch.busy_of_kind, e.busy_of_kind);
          if (out_ch.pool_size !== e.pool_size)
            report_mismatch("pool_size", out_ch.pool_size, e.pool_size);
          if (out_ch.peak_size !== e.peak_size)
            report_mismatch("peak_size", out_ch.peak_size, e.peak_size);
          if (out_ch.hit_total !== e.hit_total)
            report_mismatch("hit_total", out_ch.hit_total, e.hit_total);
          if (out_ch.miss_total !== e.miss_total)
            report_mismatch("miss_total", out_ch.miss_total, e.miss_total);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tb_pool_types::request_t make_request(trp_pkg::action_t a,
                                                           logic [2:0] k, logic [31:0] rid,
                                                           logic [4:0] cnt,
                                                           logic [31:0] now);
    tb_pool_types::request_t r;
    r.action = a; r.res_kind = k; r.release_id = rid;
    r.prewarm_count = cnt; r.now_ms = now;
    return r;
  endfunction

  function automatic void add_request(trp_pkg::action_t a, logic [2:0] k, logic [31:0] rid,
                                      logic [4:0] cnt, logic [31:0] now);
    pending_requests = {pending_requests, make_request(a, k, rid, cnt, now)};
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_ch.valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Each write deasserts valid before it returns, so back-to-back calls never drive valid twice at once.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      trp_pkg::CFG_MAX_POOL_SIZE:  r_max = value[4:0];
      trp_pkg::CFG_MIN_POOL_SIZE:  r_min = value[4:0];
      trp_pkg::CFG_TTL_SECONDS:    r_ttl = value;
      trp_pkg::CFG_ENABLE_PREWARM: r_prewarm = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly checkout/return traffic on a moving clock, so ids cycle and evicts bite.
  task automatic queue_random(int n, logic [31:0] base_ms);
    logic [31:0] now;
    int unsigned pick;
    trp_pkg::action_t a;
    now = base_ms;
    for (int i = 0; i < n; i++) begin
      now = now + $urandom_range(4000);
      if ($urandom_range(49) == 0) now = $urandom;
      pick = $urandom_range(99);
      if (pick < 40) a = trp_pkg::ACT_CHECKOUT;
      else if (pick < 70) a = trp_pkg::ACT_RETURN;
      else if (pick < 80) a = trp_pkg::ACT_EVICT;
      else if (pick < 88) a = trp_pkg::ACT_PREWARM;
      else if (pick < 93) a = trp_pkg::ACT_INIT;
      else if (pick < 96) a = trp_pkg::ACT_SHUTDOWN;
      else a = trp_pkg::action_t'($urandom_range(7));
      add_request(a,
        ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(KINDS-1)),
        ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(p_next_id + 3)),
        5'($urandom_range(31) < 4 ? $urandom_range(31) : $urandom_range(16)), now);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = trp_pkg::ACT_INIT;
    in_ch.res_kind = '0;
    in_ch.release_id = '0;
    in_ch.prewarm_count = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = trp_pkg::CFG_MAX_POOL_SIZE;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: calls before init, init twice, full pool, bad kinds, wrap, reserved.
    add_request(trp_pkg::ACT_CHECKOUT, 3'd5, '0, '0, 32'd10);
    add_request(trp_pkg::ACT_RETURN, 3'd5, 32'd1, '0, 32'd20);
    add_request(trp_pkg::ACT_PREWARM, 3'd0, '0, 5'd31, 32'd30);
    add_request(trp_pkg::ACT_SHUTDOWN, 3'd0, '0, '0, 32'd40);
    add_request(trp_pkg::ACT_INIT, 3'd0, '0, '0, 32'd50);
    add_request(trp_pkg::ACT_INIT, 3'd1, '0, '0, 32'd60);
    add_request(trp_pkg::ACT_CHECKOUT, 3'd0, '0, '0, 32'hFFFF_FFF0);
    add_request(trp_pkg::ACT_CHECKOUT, 3'd6, '0, '0, 32'd70);
    add_request(trp_pkg::ACT_CHECKOUT, 3'd7, '0, '0, 32'd70);
    add_request(trp_pkg::ACT_RETURN, 3'd0, 32'd1, '0, 32'hFFFF_FFFF);
    add_request(trp_pkg::ACT_RETURN, 3'd0, 32'd1, '0, 32'd80);
    add_request(trp_pkg::ACT_RETURN, 3'd0, 32'hFFFF_FFFF, '0, 32'd80);
    add_request(trp_pkg::ACT_PREWARM, 3'd7, '0, 5'd16, 32'd90);
    for (int k = 0; k < 5; k++)
      add_request(trp_pkg::ACT_CHECKOUT, 3'd1, '0, '0, 32'd100);
    add_request(trp_pkg::ACT_EVICT, 3'd2, '0, '0, 32'd60_050);
    add_request(trp_pkg::ACT_EVICT, 3'd2, '0, '0, 32'd60_051);
    add_request(trp_pkg::ACT_RSVD6, 3'd1, '0, '0, 32'd0);
    add_request(trp_pkg::ACT_RSVD7, 3'd4, '0, '0, 32'd0);
    wait_drained();

    // Single-entry pool, zero TTL, no prewarm.
    write_reg(trp_pkg::CFG_MAX_POOL_SIZE, 16'd1);
    write_reg(trp_pkg::CFG_MIN_POOL_SIZE, 16'd0);
    write_reg(trp_pkg::CFG_TTL_SECONDS, 16'd0);
    write_reg(trp_pkg::CFG_ENABLE_PREWARM, 16'd0);
    add_request(trp_pkg::ACT_SHUTDOWN, 3'd0, '0, '0, '0);
    add_request(trp_pkg::ACT_INIT, 3'd0, '0, '0, '0);
    queue_random(150, 32'd0);
    wait_drained();

    // Oversized limit and longest TTL.
    write_reg(trp_pkg::CFG_MAX_POOL_SIZE, 16'd31);
    write_reg(trp_pkg::CFG_MIN_POOL_SIZE, 16'd31);
    write_reg(trp_pkg::CFG_TTL_SECONDS, 16'hFFFF);
    write_reg(trp_pkg::CFG_ENABLE_PREWARM, 16'd1);
    queue_random(150, 32'hFFF0_0000);
    wait_drained();

    send_idle_pct = 66; recv_idle_pct = 14;
    write_reg(trp_pkg::CFG_MAX_POOL_SIZE, 16'd12);
    write_reg(trp_pkg::CFG_MIN_POOL_SIZE, 16'd1);
    write_reg(trp_pkg::CFG_TTL_SECONDS, 16'd3);
    queue_random(150, 32'd5000);
    // Hold the sender until every queued result has drained, then resume.
    hold_sender <= 1'b1;
    repeat (200) @(posedge clk);
    while (in_ch.valid || expected_outcomes.size() > 0) @(posedge clk);
    hold_sender <= 1'b0;
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(trp_pkg::CFG_MAX_POOL_SIZE, 16'd16);
    write_reg(trp_pkg::CFG_MIN_POOL_SIZE, 16'd2);
    write_reg(trp_pkg::CFG_TTL_SECONDS, 16'd5);
    queue_random(450, 32'd0);
    wait_drained();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
sv/trp_pkg.sv
sv/trp_if.sv
sv/trp_ram.sv
sv/trp_ctrl.sv
sv/trp_datapath.sv
sv/typed_resource_pool_ttl_unit.sv
tb/tb_pool_if.sv
tb/tb.sv
